// ===== rtl/core/vpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared constants, codes and types of the video packet deframer.
// ----------------------------------------------------------------------------
package vpd_pkg;

   localparam int DEFAULT_CONFIG_DEPTH = 64;
   localparam int HEADER_BYTES         = 12;
   localparam int DATA_W               = 8;
   localparam int SIZE_W               = 32;
   localparam int LEN_W                = 25;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(20 * 1024 * 1024);

   // header byte positions
   localparam logic [3:0] HDR_LAST       = 4'(HEADER_BYTES - 1);
   localparam logic [3:0] HDR_SIZE_FIRST = 4'(HEADER_BYTES - 4);

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_SIZE = 2'd1;
   localparam logic [1:0] ERR_CFG_LONG = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              packet_start;
      logic              packet_end;
      logic [1:0]        error_code;
   } result_type;

   typedef struct packed {
      logic wr_en;
      logic replay_start;
   } store_ctl_type;

endpackage

// ===== rtl/core/video_packet_deframer.sv =====
// A result beat appears in the cycle after its input byte; replay beats follow
// the last header byte via the store state, read data and output registers.
// One stream byte per cycle is taken while output is free and no replay runs;
// a replay holds input for each stored byte (read port, then output register).
// Reset: synchronous; clears all control state and empties the config store
// at once; store contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
// video_packet_deframer
// Splits a length-prefixed byte stream into packets, stores config payloads
// and replays them ahead of the next non-empty media payload.
// ----------------------------------------------------------------------------
module video_packet_deframer
   import vpd_pkg::*;
#(
   parameter int CONFIG_DEPTH = DEFAULT_CONFIG_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [DATA_W-1:0] req_stream_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_data_byte,
   output logic              rsp_packet_start,
   output logic              rsp_packet_end,
   output logic [1:0]        rsp_error_code,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LEN_W-1:0]  csr_max_payload
);

   localparam int AW = (CONFIG_DEPTH > 1) ? $clog2(CONFIG_DEPTH) : 1;
   localparam int LW = $clog2(CONFIG_DEPTH + 1);

   logic [LEN_W-1:0]  max_payload_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic              step;
   logic              slot_free;
   logic              res_valid;
   result_type        res;
   store_ctl_type     ctl;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [LW-1:0]     replay_len;
   logic              busy;
   logic              beat_valid;
   result_type        beat;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = slot_free && !busy;
   assign step      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   vpd_parser #(
      .CONFIG_DEPTH(CONFIG_DEPTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .stream_byte (req_stream_byte),
      .max_payload (max_payload_ff),
      .res_valid   (res_valid),
      .res         (res),
      .ctl         (ctl),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .replay_len  (replay_len)
   );

   vpd_store #(
      .CONFIG_DEPTH(CONFIG_DEPTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .replay_len (replay_len),
      .slot_free  (slot_free),
      .busy       (busy),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   // load a parser result or a replay beat, else drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (beat_valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = beat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            max_payload_ff <= csr_max_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_byte    = rsp_ff.data_byte;
   assign rsp_packet_start = rsp_ff.packet_start;
   assign rsp_packet_end   = rsp_ff.packet_end;
   assign rsp_error_code   = rsp_ff.error_code;

endmodule

// ===== rtl/core/vpd_parser.sv =====
// ----------------------------------------------------------------------------
// vpd_parser
// Header and payload tracking: size check, config capture, media pass-through.
// ----------------------------------------------------------------------------
module vpd_parser
   import vpd_pkg::*;
#(
   parameter int CONFIG_DEPTH = DEFAULT_CONFIG_DEPTH,
   localparam int AW = (CONFIG_DEPTH > 1) ? $clog2(CONFIG_DEPTH) : 1,
   localparam int LW = $clog2(CONFIG_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [DATA_W-1:0] stream_byte,
   input  logic [LEN_W-1:0]  max_payload,
   output logic              res_valid,
   output result_type        res,
   output store_ctl_type     ctl,
   output logic [AW-1:0]     wr_addr,
   output logic [DATA_W-1:0] wr_data,
   output logic [LW-1:0]     replay_len
);

   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(CONFIG_DEPTH);

   logic              in_payload_ff, in_payload_in;
   logic [3:0]        header_count_ff, header_count_in;
   logic              config_flag_ff, config_flag_in;
   logic [SIZE_W-1:0] size_accum_ff, size_accum_in;
   logic [LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic              skip_ff, skip_in;
   logic              first_ff, first_in;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [LW-1:0]     config_length_ff, config_length_in;
   logic              halted_ff, halted_in;

   logic [SIZE_W-1:0] size_next;
   logic              over_max;

   assign size_next = (header_count_ff >= HDR_SIZE_FIRST) ?
                      {size_accum_ff[SIZE_W-DATA_W-1:0], stream_byte} : size_accum_ff;
   assign over_max  = size_next[SIZE_W-1] || (|size_next[SIZE_W-2:LEN_W]) ||
                      (size_next[LEN_W-1:0] > max_payload);

   assign wr_addr    = wr_ptr_ff;
   assign wr_data    = stream_byte;
   assign replay_len = config_length_ff;

   always_comb begin
      in_payload_in    = in_payload_ff;
      header_count_in  = header_count_ff;
      config_flag_in   = config_flag_ff;
      size_accum_in    = size_accum_ff;
      bytes_left_in    = bytes_left_ff;
      skip_in          = skip_ff;
      first_in         = first_ff;
      wr_ptr_in        = wr_ptr_ff;
      config_length_in = config_length_ff;
      halted_in        = halted_ff;
      res_valid        = 1'b0;
      res              = '0;
      res.error_code   = ERR_NONE;
      ctl              = '0;
      if (step && !halted_ff) begin
         if (!in_payload_ff) begin
            size_accum_in = size_next;
            if (header_count_ff == 4'd0) begin
               config_flag_in = stream_byte[DATA_W-1];
            end
            if (header_count_ff != HDR_LAST) begin
               header_count_in = header_count_ff + 4'd1;
            end else begin
               header_count_in = 4'd0;
               if (over_max) begin
                  halted_in      = 1'b1;
                  res_valid      = 1'b1;
                  res.error_code = ERR_BAD_SIZE;
               end else if (size_next != '0) begin
                  in_payload_in = 1'b1;
                  bytes_left_in = size_next[LEN_W-1:0];
                  skip_in       = 1'b0;
                  first_in      = 1'b1;
                  wr_ptr_in     = '0;
                  if (config_flag_ff) begin
                     if (size_next[LEN_W-1:0] > DEPTH_LEN) begin
                        skip_in        = 1'b1;
                        res_valid      = 1'b1;
                        res.error_code = ERR_CFG_LONG;
                     end
                  end else if (config_length_ff != '0) begin
                     ctl.replay_start = 1'b1;
                  end
               end
            end
         end else begin
            bytes_left_in = bytes_left_ff - LEN_W'(1);
            if (bytes_left_ff == LEN_W'(1)) begin
               in_payload_in = 1'b0;
            end
            if (config_flag_ff) begin
               if (!skip_ff) begin
                  ctl.wr_en = 1'b1;
                  wr_ptr_in = wr_ptr_ff + AW'(1);
               end
               if (bytes_left_ff == LEN_W'(1)) begin
                  if (!skip_ff) begin
                     config_length_in = size_accum_ff[LW-1:0];
                  end
                  skip_in = 1'b0;
               end
            end else begin
               res_valid        = 1'b1;
               res.data_byte    = stream_byte;
               res.packet_start = first_ff && (config_length_ff == '0);
               res.packet_end   = (bytes_left_ff == LEN_W'(1));
               first_in         = 1'b0;
               if (first_ff) begin
                  config_length_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff    <= 1'b0;
         header_count_ff  <= 4'd0;
         config_flag_ff   <= 1'b0;
         size_accum_ff    <= '0;
         bytes_left_ff    <= '0;
         skip_ff          <= 1'b0;
         first_ff         <= 1'b0;
         wr_ptr_ff        <= '0;
         config_length_ff <= '0;
         halted_ff        <= 1'b0;
      end else begin
         in_payload_ff    <= in_payload_in;
         header_count_ff  <= header_count_in;
         config_flag_ff   <= config_flag_in;
         size_accum_ff    <= size_accum_in;
         bytes_left_ff    <= bytes_left_in;
         skip_ff          <= skip_in;
         first_ff         <= first_in;
         wr_ptr_ff        <= wr_ptr_in;
         config_length_ff <= config_length_in;
         halted_ff        <= halted_in;
      end
   end

endmodule

// ===== rtl/core/vpd_store.sv =====
// ----------------------------------------------------------------------------
// vpd_store
// Config byte store with one write and one registered read port, plus the
// sequencer that replays the stored bytes ahead of a media payload.
// ----------------------------------------------------------------------------
module vpd_store
   import vpd_pkg::*;
#(
   parameter int CONFIG_DEPTH = DEFAULT_CONFIG_DEPTH,
   localparam int AW = (CONFIG_DEPTH > 1) ? $clog2(CONFIG_DEPTH) : 1,
   localparam int LW = $clog2(CONFIG_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  store_ctl_type     ctl,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [LW-1:0]     replay_len,
   input  logic              slot_free,
   output logic              busy,
   output logic              beat_valid,
   output result_type        beat
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [DATA_W-1:0] mem [CONFIG_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [1:0]    state_ff, state_in;
   logic [LW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] len_ff, len_in;
   logic          rd_en;

   assign rd_en      = (state_ff == ST_READ);
   assign busy       = (state_ff != ST_IDLE);
   assign beat_valid = (state_ff == ST_SEND);

   always_comb begin
      beat              = '0;
      beat.data_byte    = rd_data_ff;
      beat.packet_start = (rd_ptr_ff == '0);
      beat.error_code   = ERR_NONE;
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff[AW-1:0]];
      end
   end

   always_comb begin
      state_in  = state_ff;
      rd_ptr_in = rd_ptr_ff;
      len_in    = len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.replay_start) begin
               rd_ptr_in = '0;
               len_in    = replay_len;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (slot_free) begin
               rd_ptr_in = rd_ptr_ff + LW'(1);
               state_in  = (rd_ptr_ff + LW'(1) == len_ff) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_ptr_ff <= '0;
         len_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         len_ff    <= len_in;
      end
   end

endmodule

// ===== sim/video_packet_deframer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_packet_deframer_checker
// Watches the stream, result and register channels of the deframer, predicts
// every result beat from the accepted stream bytes and compares each accepted
// result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module video_packet_deframer_checker
   import vpd_pkg::*;
#(
   parameter int CONFIG_DEPTH = DEFAULT_CONFIG_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [DATA_W-1:0] req_stream_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [DATA_W-1:0] rsp_data_byte,
   input  logic              rsp_packet_start,
   input  logic              rsp_packet_end,
   input  logic [1:0]        rsp_error_code,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [LEN_W-1:0]  csr_max_payload,
   output int                mismatch_count,
   output int                pending_count
);

   logic              in_payload;
   logic [3:0]        header_pos;
   logic              config_pkt;
   logic [SIZE_W-1:0] size_word;
   logic [LEN_W-1:0]  bytes_left;
   logic              skipping;
   logic [DATA_W-1:0] config_mem [CONFIG_DEPTH];
   logic [6:0]        config_len;
   logic              halted;
   logic [LEN_W-1:0]  payload_limit;
   result_type        outgoing_beats [$];
   result_type        oldest;

   task automatic queue_beat(input logic [DATA_W-1:0] data, input logic first,
                             input logic last, input logic [1:0] code);
      result_type beat;
      beat.data_byte    = data;
      beat.packet_start = first;
      beat.packet_end   = last;
      beat.error_code   = code;
      outgoing_beats = {outgoing_beats, beat};
   endtask

   task automatic deframe_byte(input logic [DATA_W-1:0] value);
      logic [SIZE_W-1:0] pos;
      logic              first;
      if (halted)
         return;
      if (!in_payload) begin
         if (header_pos == 0)
            config_pkt = value[7];
         if (header_pos >= HDR_SIZE_FIRST)
            size_word = {size_word[SIZE_W-9:0], value};
         if (header_pos != HDR_LAST) begin
            header_pos++;
            return;
         end
         header_pos = 0;
         if (size_word[SIZE_W-1] || size_word > SIZE_W'(payload_limit)) begin
            halted = 1'b1;
            queue_beat('0, 1'b0, 1'b0, ERR_BAD_SIZE);
            return;
         end
         if (size_word == 0)
            return;
         in_payload = 1'b1;
         bytes_left = size_word[LEN_W-1:0];
         skipping   = 1'b0;
         if (config_pkt) begin
            if (size_word > SIZE_W'(CONFIG_DEPTH)) begin
               skipping = 1'b1;
               queue_beat('0, 1'b0, 1'b0, ERR_CFG_LONG);
            end
         end else begin
            // replay the stored config ahead of the media payload
            for (int k = 0; k < int'(config_len); k++)
               queue_beat(config_mem[k], k == 0, 1'b0, ERR_NONE);
         end
         return;
      end
      pos = size_word - SIZE_W'(bytes_left);
      if (config_pkt) begin
         if (!skipping && pos < SIZE_W'(CONFIG_DEPTH))
            config_mem[pos] = value;
         bytes_left--;
         if (bytes_left == 0) begin
            in_payload = 1'b0;
            if (!skipping && size_word <= SIZE_W'(CONFIG_DEPTH))
               config_len = size_word[6:0];
            skipping = 1'b0;
         end
      end else begin
         first = (SIZE_W'(bytes_left) == size_word);
         queue_beat(value, first && config_len == 0, bytes_left <= 1, ERR_NONE);
         if (first)
            config_len = '0;
         bytes_left--;
         if (bytes_left == 0)
            in_payload = 1'b0;
      end
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         in_payload    = 1'b0;
         header_pos    = '0;
         config_pkt    = 1'b0;
         size_word     = '0;
         bytes_left    = '0;
         skipping      = 1'b0;
         config_len    = '0;
         halted        = 1'b0;
         payload_limit = MAX_PAYLOAD_RESET;
         outgoing_beats.delete();
      end else begin
         if (csr_valid && csr_ready)
            payload_limit = csr_max_payload;
         if (rsp_valid && rsp_ready) begin
            if (outgoing_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual data %0d code %0d",
                        $time, rsp_data_byte, rsp_error_code);
               mismatch_count++;
            end else begin
               oldest = outgoing_beats.pop_front();
               compare_field("data_byte", oldest.data_byte, rsp_data_byte);
               compare_field("packet_start", oldest.packet_start, rsp_packet_start);
               compare_field("packet_end", oldest.packet_end, rsp_packet_end);
               compare_field("error_code", oldest.error_code, rsp_error_code);
            end
         end
         if (req_valid && req_ready)
            deframe_byte(req_stream_byte);
      end
      pending_count <= outgoing_beats.size();
   end

endmodule

// ===== sim/video_packet_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_packet_deframer_tb
// Drives framed byte streams into the deframer: zero-size headers first, then
// random media and config packets under two payload limits, with a long
// receiver hold-off, and a bad size at the end that halts the block. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module video_packet_deframer_tb;
   import vpd_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [DATA_W-1:0] req_stream_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [DATA_W-1:0] rsp_data_byte;
   logic              rsp_packet_start;
   logic              rsp_packet_end;
   logic [1:0]        rsp_error_code;
   logic              csr_valid;
   logic              csr_ready;
   logic [LEN_W-1:0]  csr_max_payload;

   int                mismatch_count;
   int                pending_count;
   int                cycle_count;
   int                beats_sent;
   int                burst_left;
   int                config_turn;
   logic [LEN_W-1:0]  limit_now;
   logic              stress_phase;

   video_packet_deframer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_packet_start (rsp_packet_start),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_error_code   (rsp_error_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_payload  (csr_max_payload)
   );

   video_packet_deframer_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_packet_start (rsp_packet_start),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_error_code   (rsp_error_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_payload  (csr_max_payload),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // receiver: stall on changing patterns, hold off once for a long stretch
   initial begin : rsp_drain
      int  mode;
      int  span;
      bit  held;
      held = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 60);
         repeat (span) begin
            if (stress_phase && !held) begin
               held = 1'b1;
               rsp_ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end
            case (mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= 1'($urandom);
               end
               default: begin
                  rsp_ready <= ($urandom_range(0, 3) == 0);
               end
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_beat(input logic [DATA_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_stream_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_header(input logic [63:0] stamp, input logic [31:0] size);
      for (int i = 7; i >= 0; i--)
         send_beat(stamp[8*i +: 8]);
      for (int i = 3; i >= 0; i--)
         send_beat(size[8*i +: 8]);
   endtask

   task automatic send_random_packet();
      int          kind;
      logic        cfg;
      logic [31:0] size;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         cfg  = 1'($urandom);
         size = '0;
      end else if (kind <= 3) begin
         cfg = 1'b1;
         case (config_turn % 4)
            0:       size = DEFAULT_CONFIG_DEPTH;
            1:       size = DEFAULT_CONFIG_DEPTH + 1 + $urandom_range(0, 5);
            2:       size = $urandom_range(1, 8);
            default: size = $urandom_range(1, DEFAULT_CONFIG_DEPTH);
         endcase
         config_turn++;
      end else begin
         cfg = 1'b0;
         case ($urandom_range(0, 3))
            0:       size = 1;
            3:       size = (limit_now <= 80) ? 32'(limit_now) : $urandom_range(1, 20);
            default: size = $urandom_range(1, 10);
         endcase
      end
      if (size > 32'(limit_now))
         size = 32'(limit_now);
      send_header({cfg, 31'($urandom), 32'($urandom)}, size);
      repeat (size) send_beat(8'($urandom));
   endtask

   task automatic write_max_payload(input logic [LEN_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_max_payload <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      limit_now = value;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int          goal;
      logic [31:0] bad_size;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_stream_byte <= '0;
      csr_valid       <= 1'b0;
      csr_max_payload <= '0;
      stress_phase    = 1'b0;
      beats_sent      = 0;
      burst_left      = 0;
      config_turn     = 0;
      limit_now       = MAX_PAYLOAD_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // zero limit: only empty packets pass, stamps at both byte extremes
      write_max_payload('0);
      send_header({64{1'b1}}, '0);
      send_header('0, '0);
      wait_idle();

      write_max_payload({LEN_W{1'b1}});
      stress_phase = 1'b1;
      goal = beats_sent + 70;
      while (beats_sent < goal)
         send_random_packet();
      wait_idle();

      write_max_payload(LEN_W'($urandom_range(8, 70)));
      goal = beats_sent + 60;
      while (beats_sent < goal)
         send_random_packet();
      wait_idle();

      // halt with a negative or oversized length, then offer a few more bytes
      write_max_payload(LEN_W'($urandom));
      if ($urandom_range(0, 1) == 0)
         bad_size = {1'b1, 31'($urandom)};
      else
         bad_size = $urandom_range(32'(limit_now) + 1, 32'h7FFF_FFFF);
      send_header({1'($urandom), 31'($urandom), 32'($urandom)}, bad_size);
      repeat (3) send_beat(8'($urandom));
      wait_idle();

      if (mismatch_count == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
